// File: rtl/gb3_pkg.sv
// Shared constants, weights and control structures of the 3x3 Gaussian blur stream unit.
package gb3_pkg;

    // Line geometry.
    localparam int MAX_LINE_WIDTH = 2048;
    localparam int COL_W          = $clog2(MAX_LINE_WIDTH);
    localparam int ROW_W          = 16;
    localparam int PIX_W          = 8;
    localparam int WIDTH_REG_W    = 12;
    localparam int OUT_COL_W      = 11;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register indexes, taken from paddr[2].
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [ROW_W-1:0]       HEIGHT_RESET = 16'd480;

    // Q0.16 blur weights.
    localparam int          WEIGHT_W      = 13;
    localparam int          FRAC_W        = 16;
    localparam logic [WEIGHT_W-1:0] WEIGHT_EDGE   = 13'd5505;
    localparam logic [WEIGHT_W-1:0] WEIGHT_CORNER = 13'd4129;

    // Widths of the floored partial terms (at most 64, 42, 32 and 32).
    localparam int TERM3_W = 7;
    localparam int TERM2_W = 6;

    // Frame geometry and restart strobe from the register block.
    typedef struct packed {
        logic             restart;
        logic [COL_W-1:0] col_last;
        logic [ROW_W-1:0] row_last;
    } gb3_cfg_t;

    // Pipeline enables from the top level to the window datapath.
    typedef struct packed {
        logic clear;
        logic shift;
        logic load_p;
        logic load_o;
    } gb3_ctrl_t;

endpackage

// File: rtl/gb3_cfg_regs.sv
// Configuration registers for image width and height, with clamping to the usable geometry.
module gb3_cfg_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [gb3_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [gb3_pkg::APB_DATA_W-1:0] pwdata,
    output logic [gb3_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output gb3_pkg::gb3_cfg_t              cfg
);
    import gb3_pkg::*;

    logic [WIDTH_REG_W-1:0] width_reg;
    logic [ROW_W-1:0]       height_reg;
    logic                   wr_transfer;
    logic                   reg_idx;

    assign pready      = 1'b1;
    assign reg_idx     = paddr[2];
    assign wr_transfer = psel && penable && pwrite && pready;

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (wr_transfer)
        begin
            unique case (reg_idx)
                REG_IMAGE_WIDTH:  width_reg  <= pwdata[WIDTH_REG_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= pwdata[ROW_W-1:0];
                default:          width_reg  <= width_reg;
            endcase
        end
    end

    // Register reads.
    always_comb
    begin
        unique case (reg_idx)
            REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(width_reg);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(height_reg);
            default:          prdata = '0;
        endcase
    end

    // Last column and last row of the effective frame.
    always_comb
    begin
        cfg.restart = wr_transfer;
        if (width_reg < WIDTH_REG_W'(3))
            cfg.col_last = COL_W'(2);
        else if (32'(width_reg) > MAX_LINE_WIDTH)
            cfg.col_last = COL_W'(MAX_LINE_WIDTH - 1);
        else
            cfg.col_last = COL_W'(width_reg - WIDTH_REG_W'(1));

        if (height_reg < ROW_W'(3))
            cfg.row_last = ROW_W'(2);
        else
            cfg.row_last = height_reg - ROW_W'(1);
    end

endmodule

// File: rtl/gb3_line_buffer.sv
// Two line memories holding the two previous image rows, with registered reads.
module gb3_line_buffer
(
    input  logic                      clk,
    input  logic                      rd_en,
    input  logic [gb3_pkg::COL_W-1:0] rd_addr,
    input  logic                      wr_en,
    input  logic [gb3_pkg::COL_W-1:0] wr_addr,
    input  logic [gb3_pkg::PIX_W-1:0] wr_upper,
    input  logic [gb3_pkg::PIX_W-1:0] wr_middle,
    output logic [gb3_pkg::PIX_W-1:0] rd_upper,
    output logic [gb3_pkg::PIX_W-1:0] rd_middle
);
    import gb3_pkg::*;

    logic [PIX_W-1:0] upper_mem_reg  [MAX_LINE_WIDTH];
    logic [PIX_W-1:0] middle_mem_reg [MAX_LINE_WIDTH];
    logic [PIX_W-1:0] rd_upper_reg;
    logic [PIX_W-1:0] rd_middle_reg;

    // Write port: the pixel moves from the middle row into the upper row.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            upper_mem_reg[wr_addr]  <= wr_upper;
            middle_mem_reg[wr_addr] <= wr_middle;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_upper_reg  <= upper_mem_reg[rd_addr];
            rd_middle_reg <= middle_mem_reg[rd_addr];
        end
    end

    assign rd_upper  = rd_upper_reg;
    assign rd_middle = rd_middle_reg;

endmodule

// File: rtl/gb3_window_mac.sv
// 3x3 window registers, weighted partial terms and the final blur sum.
module gb3_window_mac
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  gb3_pkg::gb3_ctrl_t        ctrl,
    input  logic [gb3_pkg::PIX_W-1:0] top,
    input  logic [gb3_pkg::PIX_W-1:0] mid,
    input  logic [gb3_pkg::PIX_W-1:0] bot,
    output logic [gb3_pkg::PIX_W-1:0] blurred
);
    import gb3_pkg::*;

    localparam int SUM3_W  = PIX_W + 2;
    localparam int SUM2_W  = PIX_W + 1;
    localparam int PROD3_W = WEIGHT_W + SUM3_W;
    localparam int PROD2_W = WEIGHT_W + SUM2_W;

    // Columns c-2 (entries 0..2) and c-1 (entries 3..5), each top, middle, bottom.
    logic [PIX_W-1:0]   win_reg [6];

    logic [SUM3_W-1:0]  sum_cross;
    logic [SUM2_W-1:0]  sum_mid;
    logic [SUM2_W-1:0]  sum_bot;
    logic [SUM2_W-1:0]  sum_top;
    logic [PROD3_W-1:0] prod_cross;
    logic [PROD2_W-1:0] prod_mid;
    logic [PROD2_W-1:0] prod_bot;
    logic [PROD2_W-1:0] prod_top;

    logic [TERM3_W-1:0] term_cross_reg;
    logic [TERM2_W-1:0] term_mid_reg;
    logic [TERM2_W-1:0] term_bot_reg;
    logic [TERM2_W-1:0] term_top_reg;
    logic [PIX_W-1:0]   blurred_reg;
    logic [PIX_W-1:0]   blurred_next;

    // Window shift as each pixel leaves the read stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                win_reg[i] <= '0;
        end
        else if (ctrl.clear)
        begin
            for (int i = 0; i < 6; i++)
                win_reg[i] <= '0;
        end
        else if (ctrl.shift)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top;
            win_reg[4] <= mid;
            win_reg[5] <= bot;
        end
    end

    // Four independent weighted terms, each floored on its own.
    always_comb
    begin
        sum_cross  = SUM3_W'(win_reg[3]) + SUM3_W'(win_reg[4]) + SUM3_W'(win_reg[5]);
        sum_mid    = SUM2_W'(mid) + SUM2_W'(win_reg[1]);
        sum_bot    = SUM2_W'(bot) + SUM2_W'(win_reg[2]);
        sum_top    = SUM2_W'(top) + SUM2_W'(win_reg[0]);
        prod_cross = PROD3_W'(WEIGHT_EDGE) * PROD3_W'(sum_cross);
        prod_mid   = PROD2_W'(WEIGHT_EDGE) * PROD2_W'(sum_mid);
        prod_bot   = PROD2_W'(WEIGHT_CORNER) * PROD2_W'(sum_bot);
        prod_top   = PROD2_W'(WEIGHT_CORNER) * PROD2_W'(sum_top);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_p)
        begin
            term_cross_reg <= prod_cross[FRAC_W +: TERM3_W];
            term_mid_reg   <= prod_mid[FRAC_W +: TERM2_W];
            term_bot_reg   <= prod_bot[FRAC_W +: TERM2_W];
            term_top_reg   <= prod_top[FRAC_W +: TERM2_W];
        end
    end

    // Final sum; the largest possible value is 170, so no saturation.
    assign blurred_next = PIX_W'(term_cross_reg) + PIX_W'(term_mid_reg)
                        + PIX_W'(term_bot_reg) + PIX_W'(term_top_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.load_o)
            blurred_reg <= blurred_next;
    end

    assign blurred = blurred_reg;

endmodule

// File: rtl/gaussian_blur_3x3_stream_unit.sv
// Top level of the streaming 3x3 Gaussian blur: raster counters, pipeline control, instances.
//
//   Channel   Direction  Handshake                   Payload
//   pixel     in         pixel_valid / pixel_stall    pixel_value
//   result    out        result_valid / result_stall  blurred_value, out_row, out_column, is_last
//   config    in         psel, penable, pwrite, pready paddr, pwdata, prdata
//
// One pixel is accepted per clock unless stalled; the rate is set by the single read and single
// write port of each line memory, which are used once per pixel. A result passes the read, term
// and output stages after the transfer of the pixel that completes its window. These stages each
// hold under stall and empty stages fill in, so pixels keep flowing while a result waits. Reset
// clears counters, window and valid bits; the line memories are not cleared.
module gaussian_blur_3x3_stream_unit
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               pixel_valid,
    output logic                               pixel_stall,
    input  logic [gb3_pkg::PIX_W-1:0]          pixel_value,
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic [gb3_pkg::PIX_W-1:0]          blurred_value,
    output logic [gb3_pkg::ROW_W-1:0]          out_row,
    output logic [gb3_pkg::OUT_COL_W-1:0]      out_column,
    output logic                               is_last,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [gb3_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [gb3_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [gb3_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);
    import gb3_pkg::*;

    gb3_cfg_t  cfg;
    gb3_ctrl_t ctrl;

    // Position of the next incoming pixel.
    logic [COL_W-1:0]     col_reg;
    logic [ROW_W-1:0]     row_reg;

    // Read stage: memory data is valid here.
    logic                 b_valid_reg;
    logic [PIX_W-1:0]     b_pixel_reg;
    logic [COL_W-1:0]     b_col_reg;
    logic                 b_emit_reg;
    logic                 b_last_reg;
    logic [ROW_W-1:0]     b_row_out_reg;
    logic [OUT_COL_W-1:0] b_col_out_reg;

    // Term stage.
    logic                 p_valid_reg;
    logic                 p_last_reg;
    logic [ROW_W-1:0]     p_row_out_reg;
    logic [OUT_COL_W-1:0] p_col_out_reg;

    // Output stage.
    logic                 o_valid_reg;
    logic                 o_last_reg;
    logic [ROW_W-1:0]     o_row_out_reg;
    logic [OUT_COL_W-1:0] o_col_out_reg;

    logic                 o_free;
    logic                 p_free;
    logic                 b_free;
    logic                 b_move;
    logic                 accept;
    logic                 at_col_last;
    logic                 at_row_last;
    logic [PIX_W-1:0]     rd_upper;
    logic [PIX_W-1:0]     rd_middle;

    // Stage flow: each stage advances when the next one is empty or moving.
    assign o_free      = !o_valid_reg || !result_stall;
    assign p_free      = !p_valid_reg || o_free;
    assign b_free      = !b_valid_reg || p_free;
    assign b_move      = b_valid_reg && p_free;
    assign accept      = pixel_valid && b_free;
    assign pixel_stall = !b_free;

    assign at_col_last = (col_reg == cfg.col_last);
    assign at_row_last = (row_reg == cfg.row_last);

    assign ctrl.clear  = cfg.restart;
    assign ctrl.shift  = b_move;
    assign ctrl.load_p = p_free;
    assign ctrl.load_o = o_free && p_valid_reg;

    // Raster position counters; any register write restarts the frame.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg.restart)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            if (at_col_last)
            begin
                col_reg <= '0;
                row_reg <= at_row_last ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    // Valid bits of the three stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (b_free)
                b_valid_reg <= accept;
            if (p_free)
                p_valid_reg <= b_move && b_emit_reg;
            if (o_free)
                o_valid_reg <= p_valid_reg;
        end
    end

    // Read stage payload; interior test and centre position are settled at the transfer.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_pixel_reg   <= pixel_value;
            b_col_reg     <= col_reg;
            b_emit_reg    <= (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2));
            b_last_reg    <= at_row_last && at_col_last;
            b_row_out_reg <= row_reg - ROW_W'(1);
            b_col_out_reg <= OUT_COL_W'(col_reg - COL_W'(1));
        end
    end

    // Term and output stage sideband.
    always_ff @(posedge clk)
    begin
        if (p_free)
        begin
            p_last_reg    <= b_last_reg;
            p_row_out_reg <= b_row_out_reg;
            p_col_out_reg <= b_col_out_reg;
        end
        if (ctrl.load_o)
        begin
            o_last_reg    <= p_last_reg;
            o_row_out_reg <= p_row_out_reg;
            o_col_out_reg <= p_col_out_reg;
        end
    end

    gb3_cfg_regs u_cfg_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Read at the transfer, write back as the pixel leaves the read stage. The entry written
    // is the previous column, never the one read in the same cycle, and the next read of an
    // entry comes a full row later, so no forwarding is needed.
    gb3_line_buffer u_line_buffer
    (
        .clk       (clk),
        .rd_en     (accept),
        .rd_addr   (col_reg),
        .wr_en     (b_move),
        .wr_addr   (b_col_reg),
        .wr_upper  (rd_middle),
        .wr_middle (b_pixel_reg),
        .rd_upper  (rd_upper),
        .rd_middle (rd_middle)
    );

    gb3_window_mac u_window_mac
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .top     (rd_upper),
        .mid     (rd_middle),
        .bot     (b_pixel_reg),
        .blurred (blurred_value)
    );

    assign result_valid = o_valid_reg;
    assign out_row      = o_row_out_reg;
    assign out_column   = o_col_out_reg;
    assign is_last      = o_last_reg;

endmodule

// File: rtl/gb3_checker.sv
// Port-level checks of the blur unit and the bind that attaches them.
module gb3_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          pixel_stall,
    input logic                          result_valid,
    input logic                          result_stall,
    input logic [gb3_pkg::PIX_W-1:0]     blurred_value,
    input logic [gb3_pkg::ROW_W-1:0]     out_row,
    input logic [gb3_pkg::OUT_COL_W-1:0] out_column,
    input logic                          is_last
);
    import gb3_pkg::*;

    // A stalled result keeps its valid and payload.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(blurred_value)
            && $stable(out_row) && $stable(out_column) && $stable(is_last))
        else $error("stalled result changed");

    // Input back-pressure only comes from a full pipeline behind a stalled result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall |-> result_valid && result_stall)
        else $error("pixel stall without stalled result");

    // Only interior centres are reported.
    a_interior: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> out_row != '0 && out_column != '0)
        else $error("result on border position");

    // The weights sum below one, so the blur never exceeds 170.
    a_blur_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> blurred_value <= PIX_W'(170))
        else $error("blurred value out of range");

endmodule

bind gaussian_blur_3x3_stream_unit gb3_checker u_gb3_checker (.*);
